@@ hdl/ptb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants of the path transform and bounding box block.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_ADDR_W = 3;
    // 33 x 33 signed product
    localparam int PROD_W     = 66;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MAT_A       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAT_B       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAT_C       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAT_D       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAT_E       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAT_F       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_WIDTH  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_MITER_LIMIT = 3'd7;

    typedef struct packed {
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic               point_valid;
        logic               end_of_path;
    } t_point_in;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] box_x0;
        logic signed [31:0] box_y0;
        logic signed [31:0] box_x1;
        logic signed [31:0] box_y1;
        logic               box_ready;
    } t_result;

    // Operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MS_AX,
        MS_CY,
        MS_BX,
        MS_DY,
        MS_WM,
        MS_EM
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_en;
        logic     sum_x;
        logic     sum_y;
        logic     box;
        logic     ex_sat;
        logic     fin;
    } t_ctrl_cmd;

    typedef struct packed {
        logic eop;
        logic stroke;
        logic miter_big;
        logic out_free;
    } t_ctrl_stat;

endpackage : ptb_pkg
`default_nettype wire

@@ hdl/ptb_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer: steps the datapath through transform, box update, stroke
// expansion and result hand-off for one request at a time.
// ----------------------------------------------------------------------------
module ptb_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_point_valid,
    output logic                    o_in_ready,
    input  wire ptb_pkg::t_ctrl_stat i_stat,
    output ptb_pkg::t_ctrl_cmd      o_cmd
);
    import ptb_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_M_AX  = 12'b0000_0000_0010,
        S_M_CY  = 12'b0000_0000_0100,
        S_M_BX  = 12'b0000_0000_1000,
        S_M_DY  = 12'b0000_0001_0000,
        S_SUM_Y = 12'b0000_0010_0000,
        S_BOX   = 12'b0000_0100_0000,
        S_M_WM  = 12'b0000_1000_0000,
        S_SAT_W = 12'b0001_0000_0000,
        S_M_EM  = 12'b0010_0000_0000,
        S_SAT_M = 12'b0100_0000_0000,
        S_FIN   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = MS_AX;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // skip the transform for an empty path marker
                    n_state = i_point_valid ? S_M_AX : S_BOX;
                end
            end
            S_M_AX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_AX;
                n_state       = S_M_CY;
            end
            S_M_CY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_CY;
                o_cmd.acc_en  = 1'b1;
                n_state       = S_M_BX;
            end
            S_M_BX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_BX;
                o_cmd.sum_x   = 1'b1;
                n_state       = S_M_DY;
            end
            S_M_DY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_DY;
                o_cmd.acc_en  = 1'b1;
                n_state       = S_SUM_Y;
            end
            S_SUM_Y: begin
                o_cmd.sum_y = 1'b1;
                n_state     = S_BOX;
            end
            S_BOX: begin
                o_cmd.box = 1'b1;
                n_state   = (i_stat.eop && i_stat.stroke) ? S_M_WM : S_FIN;
            end
            S_M_WM: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_WM;
                n_state       = S_SAT_W;
            end
            S_SAT_W: begin
                o_cmd.ex_sat = 1'b1;
                n_state      = i_stat.miter_big ? S_M_EM : S_FIN;
            end
            S_M_EM: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_EM;
                n_state       = S_SAT_M;
            end
            S_SAT_M: begin
                o_cmd.ex_sat = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule : ptb_ctrl
`default_nettype wire

@@ hdl/ptb_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_datapath
// Configuration registers, shared multiplier, transform accumulator,
// bounding box registers, stroke expansion and output register.
// ----------------------------------------------------------------------------
module ptb_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ptb_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [ptb_pkg::DATA_W-1:0]         i_cfg_wdata,
    input  wire ptb_pkg::t_point_in                 i_in_data,
    input  wire ptb_pkg::t_ctrl_cmd                 i_cmd,
    output ptb_pkg::t_ctrl_stat                     o_stat,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output ptb_pkg::t_result                        o_out_data
);
    import ptb_pkg::*;

    localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        if ((&v[PROD_W-1:31]) || !(|v[PROD_W-1:31])) begin
            return v[31:0];
        end
        return v[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic logic [30:0] sat_pos(input logic signed [PROD_W-1:0] v);
        if (|v[PROD_W-1:31]) begin
            return 31'h7FFF_FFFF;
        end
        return v[30:0];
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] mag(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Configuration registers
    logic signed [31:0] r_mat_a, r_mat_b, r_mat_c, r_mat_d, r_mat_e, r_mat_f;
    logic signed [31:0] r_line_width;
    logic [30:0]        r_miter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat_a      <= ONE_FX;
            r_mat_b      <= '0;
            r_mat_c      <= '0;
            r_mat_d      <= ONE_FX;
            r_mat_e      <= '0;
            r_mat_f      <= '0;
            r_line_width <= '1;
            r_miter      <= ONE_FX[30:0];
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAT_A:       r_mat_a      <= i_cfg_wdata;
                CFG_MAT_B:       r_mat_b      <= i_cfg_wdata;
                CFG_MAT_C:       r_mat_c      <= i_cfg_wdata;
                CFG_MAT_D:       r_mat_d      <= i_cfg_wdata;
                CFG_MAT_E:       r_mat_e      <= i_cfg_wdata;
                CFG_MAT_F:       r_mat_f      <= i_cfg_wdata;
                CFG_LINE_WIDTH:  r_line_width <= i_cfg_wdata;
                CFG_MITER_LIMIT: r_miter      <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // Latched request
    logic signed [31:0] r_x, r_y;
    logic               r_pv, r_eop;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_in_data.x_in;
            r_y   <= i_in_data.y_in;
            r_pv  <= i_in_data.point_valid;
            r_eop <= i_in_data.end_of_path;
        end
    end

    // Shared multiplier
    logic signed [PROD_W-1:0] r_prod, r_acc;
    logic signed [32:0]       mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_sh;
    logic [31:0]              w_eff;
    logic [30:0]              r_ex;
    logic [31:0]              r_mag;

    assign w_eff = (r_line_width == 32'sd0) ? ONE_FX : r_line_width;

    always_comb begin
        case (i_cmd.mul_sel)
            MS_AX: begin
                mul_a = {r_mat_a[31], r_mat_a};
                mul_b = {r_x[31], r_x};
            end
            MS_CY: begin
                mul_a = {r_mat_c[31], r_mat_c};
                mul_b = {r_y[31], r_y};
            end
            MS_BX: begin
                mul_a = {r_mat_b[31], r_mat_b};
                mul_b = {r_x[31], r_x};
            end
            MS_DY: begin
                mul_a = {r_mat_d[31], r_mat_d};
                mul_b = {r_y[31], r_y};
            end
            MS_WM: begin
                mul_a = {1'b0, w_eff};
                mul_b = {1'b0, r_mag};
            end
            MS_EM: begin
                mul_a = {2'b00, r_ex};
                mul_b = {2'b00, r_miter};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign prod_sh = r_prod >>> FRAC_BITS;

    // Largest coefficient magnitude
    logic [31:0] mag_ab, mag_cd, mag_max;
    assign mag_ab  = (mag(r_mat_a) >= mag(r_mat_b)) ? mag(r_mat_a) : mag(r_mat_b);
    assign mag_cd  = (mag(r_mat_c) >= mag(r_mat_d)) ? mag(r_mat_c) : mag(r_mat_d);
    assign mag_max = (mag_ab >= mag_cd) ? mag_ab : mag_cd;

    logic signed [31:0] r_xo, r_yo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.acc_en) begin
            r_acc <= prod_sh;
        end
        if (i_cmd.load) begin
            r_xo <= '0;
            r_yo <= '0;
        end else if (i_cmd.sum_x) begin
            r_xo <= sat32(r_acc + prod_sh + PROD_W'(r_mat_e));
        end else if (i_cmd.sum_y) begin
            r_yo <= sat32(r_acc + prod_sh + PROD_W'(r_mat_f));
        end
        if (i_cmd.box) begin
            r_ex  <= '0;
            r_mag <= mag_max;
        end else if (i_cmd.ex_sat) begin
            r_ex <= sat_pos(prod_sh);
        end
    end

    // Bounding box
    logic signed [31:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic               r_have;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_min_y <= '0;
            r_max_x <= '0;
            r_max_y <= '0;
            r_have  <= 1'b0;
        end else if (i_cmd.box && r_pv) begin
            r_have <= 1'b1;
            if (!r_have || r_xo < r_min_x) r_min_x <= r_xo;
            if (!r_have || r_yo < r_min_y) r_min_y <= r_yo;
            if (!r_have || r_xo > r_max_x) r_max_x <= r_xo;
            if (!r_have || r_yo > r_max_y) r_max_y <= r_yo;
        end else if (i_cmd.fin && r_eop) begin
            r_have <= 1'b0;
        end
    end

    // Output register
    logic signed [32:0] ex33;
    t_result            n_out;
    t_result            r_out;
    logic               r_out_valid;

    assign ex33 = $signed({2'b00, r_ex});

    always_comb begin
        n_out           = '0;
        n_out.x_out     = r_xo;
        n_out.y_out     = r_yo;
        n_out.box_ready = r_eop;
        if (r_eop && r_have) begin
            n_out.box_x0 = sat33($signed({r_min_x[31], r_min_x}) - ex33);
            n_out.box_y0 = sat33($signed({r_min_y[31], r_min_y}) - ex33);
            n_out.box_x1 = sat33($signed({r_max_x[31], r_max_x}) + ex33);
            n_out.box_y1 = sat33($signed({r_max_y[31], r_max_y}) + ex33);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_stat.eop       = r_eop;
    assign o_stat.stroke    = (r_have || r_pv) && !r_line_width[31];
    assign o_stat.miter_big = ({1'b0, r_miter} > ONE_FX);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule : ptb_datapath
`default_nettype wire

@@ hdl/path_transform_and_bound.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// path_transform_and_bound
// Affine transform of path points with a running min/max bounding box,
// optionally widened for stroking at the end of each path.
// ----------------------------------------------------------------------------
//  Channel   Signals                              Direction  Moves
//  in        i_in_valid / o_in_ready / i_in_data  input      one point request
//  out       o_out_valid / i_out_ready / o_out_data output   one result
//  cfg       i_cfg_we / i_cfg_addr / i_cfg_wdata  input      register write
//
// One request at a time through a single shared 33x33 multiplier: a point
// runs the transform and the box update, an empty marker skips the
// transform, and an end of path with stroking adds the stroke expansion,
// with a second product when the miter limit is above 1.0.
// The result waits in an output register, so the next request runs up to
// its last step while the receiver stalls; it holds there, and no request
// is taken until the output register frees.
// Reset is synchronous, active low, and restores the register defaults.
// ----------------------------------------------------------------------------
module path_transform_and_bound #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire ptb_pkg::t_point_in             i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output ptb_pkg::t_result                    o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [ptb_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [ptb_pkg::DATA_W-1:0]     i_cfg_wdata
);
    import ptb_pkg::*;

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    ptb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_point_valid (i_in_data.point_valid),
        .o_in_ready    (o_in_ready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    ptb_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule : path_transform_and_bound
`default_nettype wire
